// ===== rtl/lfd_pkg.sv =====
// shared types, constants and helpers for the lcd frame-done register block
`timescale 1ns / 1ps

package lfd_pkg;

  // register file geometry
  localparam int REG_COUNT = 64;
  localparam int SLOT_W    = 10;
  localparam int IDX_W     = $clog2(REG_COUNT);
  localparam int DATA_W    = 32;
  localparam int PERIOD_W  = 20;

  // slots kept in flops or with side effects
  localparam logic [SLOT_W-1:0] SLOT_CTRL        = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_CTRL1       = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_CUR_BUF     = SLOT_W'(4);
  localparam logic [SLOT_W-1:0] SLOT_NEXT_BUF    = SLOT_W'(5);
  localparam logic [SLOT_W-1:0] SLOT_AS_NEXT_BUF = SLOT_W'(35);

  // control bit positions and reset values
  localparam int RUN_BIT     = 0;
  localparam int DONE_BIT    = 9;
  localparam int DONE_EN_BIT = 13;
  localparam logic [DATA_W-1:0]   CTRL1_RESET  = 32'h000f_0000;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd16000;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ALIAS_PLAIN = 2'd0,
    ALIAS_SET   = 2'd1,
    ALIAS_CLR   = 2'd2,
    ALIAS_TOG   = 2'd3
  } alias_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [13:0]       byte_offset;
    logic [DATA_W-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq_level;
  } out_item_t;

  // register file write request
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

  // read source and interrupt level for one beat
  typedef struct packed {
    logic              use_mem;
    logic [DATA_W-1:0] data;
    logic              irq;
  } rd_info_t;

  // countdown status
  typedef struct packed {
    logic                running;
    logic                armed;
    logic [PERIOD_W-1:0] countdown;
    logic [PERIOD_W-1:0] period;
  } status_t;

  // plain, set, clear or toggle update of a register word
  function automatic logic [DATA_W-1:0] apply_alias(input logic [DATA_W-1:0] oldv,
                                                    input logic [DATA_W-1:0] data,
                                                    input alias_e        al);
    logic [DATA_W-1:0] res;
    case (al)
      ALIAS_PLAIN: res = data;
      ALIAS_SET:   res = oldv | data;
      ALIAS_CLR:   res = oldv & ~data;
      ALIAS_TOG:   res = oldv ^ data;
      default:     res = data;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/lcd_frame_done_register_block_core.sv =====
// top level of the lcd frame-done register block
`timescale 1ns / 1ps

// a result passes through the first stage and then the result stage after its beat is accepted
// throughput: one beat per cycle while the result is not stalled, limited by the single register file port pair
// state is updated at the accepting edge; the result stage holds while stalled
// reset: asynchronous, clears control, control1 to 0x000f0000, period to 16000,
// countdown disarmed, all register file entries read as zero until written
module lcd_frame_done_register_block_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lfd_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lfd_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lfd_pkg::PERIOD_W-1:0]  cfg_data_i
);

  logic                       in_acc;
  logic                       p_adv;
  logic                       p_valid_q;
  lfd_pkg::rd_info_t          p_info_q;
  logic                       out_valid_q;
  lfd_pkg::out_item_t         out_q;
  lfd_pkg::mem_wr_t           wr;
  lfd_pkg::rd_info_t          rd_info;
  lfd_pkg::status_t           status;
  logic [lfd_pkg::DATA_W-1:0] mem_rdata;

  // handshake
  assign p_adv       = p_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o  = ~p_valid_q | p_adv;
  assign in_acc      = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;

  lfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .item_i      (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .wr_o        (wr),
    .rd_o        (rd_info),
    .status_o    (status)
  );

  lfd_regfile u_regfile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .re_i    (in_acc & rd_info.use_mem),
    .raddr_i (in_data_i.byte_offset[lfd_pkg::IDX_W+3:4]),
    .rdata_o (mem_rdata)
  );

  // first stage: read source and irq, paired with the memory read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (in_acc) begin
      p_valid_q <= 1'b1;
    end else if (p_adv) begin
      p_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p_info_q <= rd_info;
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (p_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_adv) begin
      out_q.read_data <= p_info_q.use_mem ? mem_rdata : p_info_q.data;
      out_q.irq_level <= p_info_q.irq;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // the countdown only runs while the run bit is set
  a_armed_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.armed |-> status.running)
    else $error("countdown armed while not running");

  // arming loads the full period
  a_arm_loads_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(status.armed) |-> status.countdown == $past(status.period))
    else $error("countdown armed with wrong count");

  // a full pipeline with a stalled result takes no new beat
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && p_valid_q) |-> !in_ready_o)
    else $error("beat accepted while pipeline is full");

endmodule

// ===== rtl/lfd_regfile.sv =====
// plain register words held in a memory with per-entry valid bits
`timescale 1ns / 1ps

module lfd_regfile (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lfd_pkg::mem_wr_t             wr_i,
  input  logic                         re_i,
  input  logic [lfd_pkg::IDX_W-1:0]    raddr_i,
  output logic [lfd_pkg::DATA_W-1:0]   rdata_o
);

  logic [lfd_pkg::DATA_W-1:0] mem [lfd_pkg::REG_COUNT];
  logic [lfd_pkg::REG_COUNT-1:0] vld_q;
  logic [lfd_pkg::DATA_W-1:0] rdata_q;
  logic                       rvld_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // valid bits, an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ===== rtl/lfd_ctrl.sv =====
// control registers, buffer address, frame countdown and beat decode
`timescale 1ns / 1ps

module lfd_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  lfd_pkg::in_item_t             item_i,
  input  logic                          cfg_valid_i,
  input  logic [lfd_pkg::PERIOD_W-1:0]  cfg_data_i,
  output lfd_pkg::mem_wr_t              wr_o,
  output lfd_pkg::rd_info_t             rd_o,
  output lfd_pkg::status_t              status_o
);

  logic [lfd_pkg::DATA_W-1:0]   ctrl_q, ctrl_d;
  logic [lfd_pkg::DATA_W-1:0]   ctrl1_q, ctrl1_d;
  logic [lfd_pkg::DATA_W-1:0]   cur_q, cur_d;
  logic [lfd_pkg::PERIOD_W-1:0] cd_q, cd_d;
  logic [lfd_pkg::PERIOD_W-1:0] period_q, period_d;
  logic                         armed_q, armed_d;

  logic [lfd_pkg::SLOT_W-1:0] slot;
  lfd_pkg::alias_e            al;
  logic                       in_range;
  logic                       is_ctrl, is_ctrl1, is_cur, is_next, is_as_next;
  logic [lfd_pkg::DATA_W-1:0] newv;

  // decode the beat
  assign slot       = item_i.byte_offset[13:4];
  assign al         = lfd_pkg::alias_e'(item_i.byte_offset[3:2]);
  assign in_range   = {1'b0, slot} < (lfd_pkg::SLOT_W + 1)'(lfd_pkg::REG_COUNT);
  assign is_ctrl    = slot == lfd_pkg::SLOT_CTRL;
  assign is_ctrl1   = slot == lfd_pkg::SLOT_CTRL1;
  assign is_cur     = slot == lfd_pkg::SLOT_CUR_BUF;
  assign is_next    = slot == lfd_pkg::SLOT_NEXT_BUF;
  assign is_as_next = slot == lfd_pkg::SLOT_AS_NEXT_BUF;

  // next state for one beat
  always_comb begin
    ctrl_d   = ctrl_q;
    ctrl1_d  = ctrl1_q;
    cur_d    = cur_q;
    cd_d     = cd_q;
    armed_d  = armed_q;
    period_d = cfg_valid_i ? cfg_data_i : period_q;
    wr_o     = '0;
    rd_o     = '0;
    newv     = '0;
    if (acc_i) begin
      case (lfd_pkg::op_e'(item_i.opcode))
        lfd_pkg::OP_READ: begin
          if (in_range) begin
            if (is_ctrl) begin
              rd_o.data = ctrl_q;
            end else if (is_ctrl1) begin
              rd_o.data = ctrl1_q;
            end else if (is_cur) begin
              rd_o.data = cur_q;
            end else begin
              rd_o.use_mem = 1'b1;
            end
          end
        end
        lfd_pkg::OP_WRITE: begin
          if (in_range && (al == lfd_pkg::ALIAS_PLAIN || is_ctrl || is_ctrl1)) begin
            if (is_ctrl) begin
              newv   = lfd_pkg::apply_alias(ctrl_q, item_i.write_data, al);
              ctrl_d = newv;
              // run rising arms unless a frame is already pending
              if (!ctrl_q[lfd_pkg::RUN_BIT] && newv[lfd_pkg::RUN_BIT]) begin
                if (!ctrl1_q[lfd_pkg::DONE_BIT]) begin
                  cd_d    = period_q;
                  armed_d = 1'b1;
                end else begin
                  armed_d = 1'b0;
                end
              end else if (ctrl_q[lfd_pkg::RUN_BIT] && !newv[lfd_pkg::RUN_BIT]) begin
                armed_d = 1'b0;
              end
            end else if (is_ctrl1) begin
              newv    = lfd_pkg::apply_alias(ctrl1_q, item_i.write_data, al);
              ctrl1_d = newv;
              // clearing frame-done rearms while running
              if (ctrl1_q[lfd_pkg::DONE_BIT] && !newv[lfd_pkg::DONE_BIT]) begin
                if (ctrl_q[lfd_pkg::RUN_BIT]) begin
                  cd_d    = period_q;
                  armed_d = 1'b1;
                end else begin
                  armed_d = 1'b0;
                end
              end
            end else if (is_cur) begin
              cur_d = item_i.write_data;
            end else begin
              wr_o.we   = 1'b1;
              wr_o.addr = slot[lfd_pkg::IDX_W-1:0];
              wr_o.data = item_i.write_data;
              // buffer flips mark the frame done and stop the countdown
              if (is_next) begin
                cur_d                      = item_i.write_data;
                ctrl1_d[lfd_pkg::DONE_BIT] = 1'b1;
                armed_d                    = 1'b0;
              end else if (is_as_next) begin
                ctrl1_d[lfd_pkg::DONE_BIT] = 1'b1;
                armed_d                    = 1'b0;
              end
            end
          end
        end
        lfd_pkg::OP_TICK: begin
          if (armed_q) begin
            if (cd_q <= lfd_pkg::PERIOD_W'(1)) begin
              cd_d    = '0;
              armed_d = 1'b0;
              if (ctrl_q[lfd_pkg::RUN_BIT] && !ctrl1_q[lfd_pkg::DONE_BIT]) begin
                ctrl1_d[lfd_pkg::DONE_BIT] = 1'b1;
              end
            end else begin
              cd_d = cd_q - lfd_pkg::PERIOD_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
    rd_o.irq = ctrl1_d[lfd_pkg::DONE_EN_BIT] & ctrl1_d[lfd_pkg::DONE_BIT];
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q   <= '0;
      ctrl1_q  <= lfd_pkg::CTRL1_RESET;
      cur_q    <= '0;
      cd_q     <= '0;
      armed_q  <= 1'b0;
      period_q <= lfd_pkg::PERIOD_RESET;
    end else begin
      ctrl_q   <= ctrl_d;
      ctrl1_q  <= ctrl1_d;
      cur_q    <= cur_d;
      cd_q     <= cd_d;
      armed_q  <= armed_d;
      period_q <= period_d;
    end
  end

  assign status_o.running   = ctrl_q[lfd_pkg::RUN_BIT];
  assign status_o.armed     = armed_q;
  assign status_o.countdown = cd_q;
  assign status_o.period    = period_q;

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for the lcd frame-done register block
`timescale 1ns / 1ps

module tb;

  // opcode outside the defined set, must change nothing
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [lfd_pkg::DATA_W-1:0] RUN_M =
    lfd_pkg::DATA_W'(1) << lfd_pkg::RUN_BIT;
  localparam logic [lfd_pkg::DATA_W-1:0] DONE_M =
    lfd_pkg::DATA_W'(1) << lfd_pkg::DONE_BIT;
  localparam logic [lfd_pkg::DATA_W-1:0] DONE_EN_M =
    lfd_pkg::DATA_W'(1) << lfd_pkg::DONE_EN_BIT;
  localparam int PHASES = 8;
  localparam int BEATS_PER_PHASE = 115;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  lfd_pkg::in_item_t            in_data = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  lfd_pkg::out_item_t           out_data;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [lfd_pkg::PERIOD_W-1:0] cfg_data = '0;

  // idle and stall odds out of a hundred, set per phase
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned fail_count = 0;

  // bus beats waiting to be driven and replies waiting to come back
  lfd_pkg::in_item_t  beat_q[$];
  lfd_pkg::out_item_t reply_q[$];
  lfd_pkg::out_item_t reply_want;

  // shadow of the register block
  logic [lfd_pkg::DATA_W-1:0]   mdl_regs [lfd_pkg::REG_COUNT];
  logic [lfd_pkg::PERIOD_W-1:0] mdl_countdown;
  logic                         mdl_armed;
  logic [lfd_pkg::PERIOD_W-1:0] mdl_period;

  lcd_frame_done_register_block_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // start the frame countdown if running with no frame done pending, else stop it
  function automatic void frame_rearm();
    if (mdl_regs[lfd_pkg::SLOT_CTRL][lfd_pkg::RUN_BIT] &&
        !mdl_regs[lfd_pkg::SLOT_CTRL1][lfd_pkg::DONE_BIT]) begin
      mdl_countdown = mdl_period;
      mdl_armed = 1'b1;
    end else begin
      mdl_armed = 1'b0;
    end
  endfunction

  // apply one bus beat to the shadow and return the reply it should produce
  function automatic lfd_pkg::out_item_t regblock_apply(input lfd_pkg::in_item_t b);
    lfd_pkg::out_item_t         r;
    logic [lfd_pkg::SLOT_W-1:0] slot;
    logic [1:0]                 al;
    logic [lfd_pkg::DATA_W-1:0] oldv;
    logic [lfd_pkg::DATA_W-1:0] newv;
    r = '0;
    slot = b.byte_offset[13:4];
    al = b.byte_offset[3:2];
    if (b.opcode == lfd_pkg::OP_READ) begin
      if (slot < lfd_pkg::REG_COUNT) r.read_data = mdl_regs[slot[lfd_pkg::IDX_W-1:0]];
    end else if (b.opcode == lfd_pkg::OP_WRITE) begin
      // aliases only exist on the two control registers
      if (slot < lfd_pkg::REG_COUNT &&
          (al == lfd_pkg::ALIAS_PLAIN || slot == lfd_pkg::SLOT_CTRL ||
           slot == lfd_pkg::SLOT_CTRL1)) begin
        oldv = mdl_regs[slot[lfd_pkg::IDX_W-1:0]];
        case (al)
          lfd_pkg::ALIAS_SET: newv = oldv | b.write_data;
          lfd_pkg::ALIAS_CLR: newv = oldv & ~b.write_data;
          lfd_pkg::ALIAS_TOG: newv = oldv ^ b.write_data;
          default:            newv = b.write_data;
        endcase
        mdl_regs[slot[lfd_pkg::IDX_W-1:0]] = newv;
        if (slot == lfd_pkg::SLOT_CTRL) begin
          if (!oldv[lfd_pkg::RUN_BIT] && newv[lfd_pkg::RUN_BIT]) frame_rearm();
          else if (oldv[lfd_pkg::RUN_BIT] && !newv[lfd_pkg::RUN_BIT]) mdl_armed = 1'b0;
        end else if (slot == lfd_pkg::SLOT_CTRL1) begin
          if (oldv[lfd_pkg::DONE_BIT] && !newv[lfd_pkg::DONE_BIT]) frame_rearm();
        end else if (slot == lfd_pkg::SLOT_NEXT_BUF ||
                     slot == lfd_pkg::SLOT_AS_NEXT_BUF) begin
          if (slot == lfd_pkg::SLOT_NEXT_BUF) mdl_regs[lfd_pkg::SLOT_CUR_BUF] = newv;
          mdl_regs[lfd_pkg::SLOT_CTRL1][lfd_pkg::DONE_BIT] = 1'b1;
          frame_rearm();
        end
      end
    end else if (b.opcode == lfd_pkg::OP_TICK && mdl_armed) begin
      // one-shot expiry, a stale one only disarms
      if (mdl_countdown <= 1) begin
        mdl_countdown = '0;
        mdl_armed = 1'b0;
        if (mdl_regs[lfd_pkg::SLOT_CTRL][lfd_pkg::RUN_BIT] &&
            !mdl_regs[lfd_pkg::SLOT_CTRL1][lfd_pkg::DONE_BIT])
          mdl_regs[lfd_pkg::SLOT_CTRL1][lfd_pkg::DONE_BIT] = 1'b1;
      end else begin
        mdl_countdown = mdl_countdown - 1'b1;
      end
    end
    r.irq_level = mdl_regs[lfd_pkg::SLOT_CTRL1][lfd_pkg::DONE_EN_BIT] &
                  mdl_regs[lfd_pkg::SLOT_CTRL1][lfd_pkg::DONE_BIT];
    return r;
  endfunction

  function automatic logic [13:0] reg_addr(input logic [lfd_pkg::SLOT_W-1:0] slot,
                                           input lfd_pkg::alias_e al);
    return {slot, al, 2'b00};
  endfunction

  task automatic add_beat(input logic [1:0] op, input logic [13:0] off,
                          input logic [lfd_pkg::DATA_W-1:0] data);
    lfd_pkg::in_item_t b;
    b.opcode = op;
    b.byte_offset = off;
    b.write_data = data;
    beat_q.push_back(b);
  endtask

  // sampled at the falling edge so the check never races the clocked blocks
  task automatic wait_drained();
    do @(negedge clk_i);
    while (beat_q.size() != 0 || in_valid || reply_q.size() != 0);
  endtask

  task automatic write_period(input logic [lfd_pkg::PERIOD_W-1:0] v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    mdl_period = v;
    @(negedge clk_i);
  endtask

  // request driver: predicts each beat as it is accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) reply_q.push_back(regblock_apply(in_data));
      if (!in_valid || in_ready) begin
        if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= beat_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // reply monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          $error("reply with no beat outstanding: read_data %h irq_level %b",
                 out_data.read_data, out_data.irq_level);
          fail_count++;
        end else begin
          reply_want = reply_q.pop_front();
          if (out_data.read_data !== reply_want.read_data) begin
            $error("read_data: expected %h, got %h",
                   reply_want.read_data, out_data.read_data);
            fail_count++;
          end
          if (out_data.irq_level !== reply_want.irq_level) begin
            $error("irq_level: expected %b, got %b",
                   reply_want.irq_level, out_data.irq_level);
            fail_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // run limit
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  // reset, directed beats, then random phases with new periods and idle and stall modes
  initial begin
    logic [lfd_pkg::PERIOD_W-1:0] periods [PHASES];
    int unsigned                  pick;
    logic [lfd_pkg::SLOT_W-1:0]   slot;
    logic [1:0]                   al;
    logic [1:0]                   op;
    logic [lfd_pkg::DATA_W-1:0]   wd;

    for (int i = 0; i < lfd_pkg::REG_COUNT; i++) mdl_regs[i] = '0;
    mdl_regs[lfd_pkg::SLOT_CTRL1] = lfd_pkg::CTRL1_RESET;
    mdl_countdown = '0;
    mdl_armed = 1'b0;
    mdl_period = lfd_pkg::PERIOD_RESET;
    periods = '{20'd3, 20'd0, 20'd1, 20'hfffff, 20'd7, 20'd2, 20'd0, 20'd0};
    periods[6] = lfd_pkg::PERIOD_W'($urandom_range(40, 1));
    periods[7] = lfd_pkg::PERIOD_W'($urandom_range(20, 4));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset values, aliases, countdown corner cases
    write_period(20'd2);
    add_beat(lfd_pkg::OP_READ, reg_addr(lfd_pkg::SLOT_CTRL1, lfd_pkg::ALIAS_PLAIN), '0);
    add_beat(lfd_pkg::OP_READ,
             reg_addr(lfd_pkg::SLOT_W'(1023), lfd_pkg::ALIAS_TOG) | 14'd3, '0);
    add_beat(OP_UNUSED, reg_addr(lfd_pkg::SLOT_CTRL1, lfd_pkg::ALIAS_PLAIN),
             32'hffff_ffff);
    add_beat(lfd_pkg::OP_WRITE, reg_addr(lfd_pkg::SLOT_CTRL1, lfd_pkg::ALIAS_SET),
             DONE_EN_M);
    add_beat(lfd_pkg::OP_WRITE, reg_addr(lfd_pkg::SLOT_CTRL, lfd_pkg::ALIAS_SET), RUN_M);
    add_beat(lfd_pkg::OP_TICK, '0, '0);
    add_beat(lfd_pkg::OP_TICK, '0, '0);
    add_beat(lfd_pkg::OP_TICK, '0, '0);
    add_beat(lfd_pkg::OP_WRITE, reg_addr(lfd_pkg::SLOT_CTRL1, lfd_pkg::ALIAS_CLR), DONE_M);
    // done set by hand while armed, so the expiry is stale
    add_beat(lfd_pkg::OP_WRITE, reg_addr(lfd_pkg::SLOT_CTRL1, lfd_pkg::ALIAS_TOG), DONE_M);
    add_beat(lfd_pkg::OP_TICK, '0, '0);
    add_beat(lfd_pkg::OP_TICK, '0, '0);
    add_beat(lfd_pkg::OP_WRITE, reg_addr(lfd_pkg::SLOT_CTRL1, lfd_pkg::ALIAS_TOG), DONE_M);
    // arming again restarts the full period
    add_beat(lfd_pkg::OP_TICK, '0, '0);
    add_beat(lfd_pkg::OP_WRITE,
             reg_addr(lfd_pkg::SLOT_CTRL1, lfd_pkg::ALIAS_SET) | 14'd1, DONE_M);
    add_beat(lfd_pkg::OP_WRITE, reg_addr(lfd_pkg::SLOT_CTRL1, lfd_pkg::ALIAS_CLR), DONE_M);
    add_beat(lfd_pkg::OP_TICK, '0, '0);
    add_beat(lfd_pkg::OP_WRITE, reg_addr(lfd_pkg::SLOT_CTRL, lfd_pkg::ALIAS_CLR), RUN_M);
    add_beat(lfd_pkg::OP_TICK, '0, '0);
    add_beat(lfd_pkg::OP_WRITE, reg_addr(lfd_pkg::SLOT_CTRL, lfd_pkg::ALIAS_TOG), RUN_M);
    add_beat(lfd_pkg::OP_WRITE, reg_addr(lfd_pkg::SLOT_NEXT_BUF, lfd_pkg::ALIAS_PLAIN),
             32'hdead_beef);
    add_beat(lfd_pkg::OP_READ,
             reg_addr(lfd_pkg::SLOT_CUR_BUF, lfd_pkg::ALIAS_PLAIN) | 14'd1, '0);
    // aliases on other registers are dropped
    add_beat(lfd_pkg::OP_WRITE, reg_addr(lfd_pkg::SLOT_AS_NEXT_BUF, lfd_pkg::ALIAS_SET),
             32'hffff_ffff);
    add_beat(lfd_pkg::OP_WRITE, reg_addr(lfd_pkg::SLOT_AS_NEXT_BUF, lfd_pkg::ALIAS_PLAIN),
             32'h1234_5678);
    add_beat(lfd_pkg::OP_READ,
             reg_addr(lfd_pkg::SLOT_AS_NEXT_BUF, lfd_pkg::ALIAS_PLAIN) | 14'd2, '0);
    add_beat(lfd_pkg::OP_WRITE, reg_addr(lfd_pkg::SLOT_W'(1023), lfd_pkg::ALIAS_PLAIN),
             32'hffff_ffff);
    add_beat(lfd_pkg::OP_WRITE, reg_addr(lfd_pkg::SLOT_CTRL, lfd_pkg::ALIAS_PLAIN),
             32'hffff_ffff);
    add_beat(lfd_pkg::OP_WRITE, reg_addr(lfd_pkg::SLOT_CTRL1, lfd_pkg::ALIAS_PLAIN),
             32'hffff_ffff);
    add_beat(lfd_pkg::OP_READ,
             reg_addr(lfd_pkg::SLOT_CTRL1, lfd_pkg::ALIAS_PLAIN) | 14'd3, '0);
    add_beat(lfd_pkg::OP_WRITE,
             reg_addr(lfd_pkg::SLOT_W'(lfd_pkg::REG_COUNT - 1), lfd_pkg::ALIAS_PLAIN),
             32'ha5a5_5a5a);
    add_beat(lfd_pkg::OP_READ,
             reg_addr(lfd_pkg::SLOT_W'(lfd_pkg::REG_COUNT - 1), lfd_pkg::ALIAS_PLAIN), '0);
    wait_drained();

    // random phases; draining between them also holds the sender off
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph / 2)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 76; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      repeat (4) @(posedge clk_i);
      write_period(periods[ph]);
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 35)      op = lfd_pkg::OP_TICK;
        else if (pick < 62) op = lfd_pkg::OP_WRITE;
        else if (pick < 95) op = lfd_pkg::OP_READ;
        else                op = OP_UNUSED;
        // the control registers most often, then any slot, some buffers, some missing slots
        pick = $urandom_range(99);
        if (pick < 45) begin
          slot = $urandom_range(1) ? lfd_pkg::SLOT_CTRL1 : lfd_pkg::SLOT_CTRL;
        end else if (pick < 60) begin
          case ($urandom_range(2))
            0:       slot = lfd_pkg::SLOT_CUR_BUF;
            1:       slot = lfd_pkg::SLOT_NEXT_BUF;
            default: slot = lfd_pkg::SLOT_AS_NEXT_BUF;
          endcase
        end else if (pick < 88) begin
          slot = lfd_pkg::SLOT_W'($urandom_range(lfd_pkg::REG_COUNT - 1));
        end else begin
          slot = lfd_pkg::SLOT_W'($urandom_range(1023, lfd_pkg::REG_COUNT));
        end
        if (slot == lfd_pkg::SLOT_CTRL || slot == lfd_pkg::SLOT_CTRL1 ||
            $urandom_range(3) == 0)
          al = 2'($urandom_range(3));
        else
          al = lfd_pkg::ALIAS_PLAIN;
        if ($urandom_range(3) == 0 || slot > lfd_pkg::SLOT_CTRL1) begin
          wd = $urandom();
        end else begin
          wd = ($urandom_range(1) ? RUN_M : '0) | ($urandom_range(1) ? DONE_M : '0) |
               ($urandom_range(3) != 0 ? DONE_EN_M : '0);
        end
        add_beat(op, reg_addr(slot, lfd_pkg::alias_e'(al)) | 14'($urandom_range(3)), wd);
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lfd_pkg.sv
rtl/lfd_regfile.sv
rtl/lfd_ctrl.sv
rtl/lcd_frame_done_register_block_core.sv
sim/tb.sv
